@@ sv/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// types and constants for the ring-store double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int CAPACITY = 64;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
    localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
    localparam logic [3:0] CMD_POP_FRONT  = 4'd2;
    localparam logic [3:0] CMD_POP_BACK   = 4'd3;
    localparam logic [3:0] CMD_CLEAR      = 4'd4;
    localparam logic [3:0] CMD_ERASE      = 4'd5;
    localparam logic [3:0] CMD_RESIZE     = 4'd6;
    localparam logic [3:0] CMD_ASSIGN     = 4'd7;
    localparam logic [3:0] CMD_REVERSE    = 4'd8;
    localparam logic [3:0] CMD_SORT       = 4'd9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [31:0] WORD_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] value;
        logic [5:0]         index;
        logic [6:0]         count;
    } t_deq_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [6:0]         size_now;
        logic               is_empty;
    } t_deq_out;

endpackage

@@ sv/double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top
// bounded deque of signed words in a single-port-read ring memory
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  command  in         i_valid / o_ready    i_data (t_deq_in)
//  result   out        o_valid / i_ready    o_data (t_deq_out)
//
//  one command at a time; resize and assign write one word at a time, and
//  erase, reverse and sort step through the stored words one by one; the
//  one memory read port sets this.
//  every command ends with a read of the front and back slots.
//  reset clears state, head, count and result valid only; the memory needs no clearing.
//  a stalled result holds the next result in its last state until the old one is taken.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  deq_pkg::t_deq_in i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output deq_pkg::t_deq_out o_data
);
    import deq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_EXEC, S_POP, S_ER_CAP, S_ER_RD, S_ER_WR, S_FILL,
        S_REV_A, S_REV_B, S_REV_C, S_REV_D,
        S_SORT_KEY, S_SORT_KEYW, S_SORT_CMP, S_SORT_PUT,
        S_FRONT, S_BACK, S_FIN
    } t_state;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   r_rdata;

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    t_deq_in       r_req, n_req;
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_removed, n_removed;
    logic [31:0]   r_lo, n_lo;
    logic [31:0]   r_front, n_front;
    logic          r_out_valid, n_out_valid;
    t_deq_out      r_out, n_out;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;
    logic [CW-1:0] hi_pos;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        return head + pos[AW-1:0];
    endfunction

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign hi_pos  = r_count - ONE_C - r_i;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_req       = r_req;
        n_status    = r_status;
        n_removed   = r_removed;
        n_lo        = r_lo;
        n_front     = r_front;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = r_head;
        wr_en       = 1'b0;
        wr_addr     = r_head;
        wr_data     = r_rdata;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req     = i_data;
                    n_status  = ST_OK;
                    n_removed = '0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FRONT;
                unique case (r_req.cmd) inside
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        if (r_count >= CAP_C) begin
                            n_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_data = r_req.value;
                            n_count = r_count + ONE_C;
                            if (r_req.cmd == CMD_PUSH_FRONT) begin
                                n_head  = r_head - AW'(1);
                                wr_addr = r_head - AW'(1);
                            end else begin
                                wr_addr = slot(r_head, r_count);
                            end
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = (r_req.cmd == CMD_POP_FRONT) ? r_head
                                      : slot(r_head, r_count - ONE_C);
                            n_state = S_POP;
                        end
                    end
                    CMD_CLEAR: n_count = '0;
                    CMD_ERASE: begin
                        if (CW'(r_req.index) >= r_count) begin
                            n_status = ST_RANGE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = slot(r_head, CW'(r_req.index));
                            n_i     = CW'(r_req.index);
                            n_state = S_ER_CAP;
                        end
                    end
                    CMD_RESIZE, CMD_ASSIGN: begin
                        if (r_req.count > CAP_C) begin
                            n_status = ST_FULL;
                        end else begin
                            n_i     = (r_req.cmd == CMD_ASSIGN) ? '0 : r_count;
                            n_state = S_FILL;
                        end
                    end
                    CMD_REVERSE: begin
                        n_i     = '0;
                        n_state = S_REV_A;
                    end
                    CMD_SORT: begin
                        n_i     = ONE_C;
                        n_state = S_SORT_KEY;
                    end
                    default: ;
                endcase
            end
            S_POP: begin
                n_removed = r_rdata;
                n_count   = r_count - ONE_C;
                if (r_req.cmd == CMD_POP_FRONT) begin
                    n_head = r_head + AW'(1);
                end
                n_state = S_FRONT;
            end
            S_ER_CAP: begin
                n_removed = r_rdata;
                n_state   = S_ER_RD;
            end
            S_ER_RD: begin
                if (r_i + ONE_C < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = slot(r_head, r_i + ONE_C);
                    n_state = S_ER_WR;
                end else begin
                    n_count = r_count - ONE_C;
                    n_state = S_FRONT;
                end
            end
            S_ER_WR: begin
                wr_en   = 1'b1;
                wr_addr = slot(r_head, r_i);
                n_i     = r_i + ONE_C;
                n_state = S_ER_RD;
            end
            S_FILL: begin
                if (r_i < r_req.count) begin
                    wr_en   = 1'b1;
                    wr_addr = slot(r_head, r_i);
                    wr_data = (r_req.cmd == CMD_ASSIGN) ? r_req.value : '0;
                    n_i     = r_i + ONE_C;
                end else begin
                    n_count = r_req.count;
                    n_state = S_FRONT;
                end
            end
            S_REV_A: begin
                if (r_i < (r_count >> 1)) begin
                    rd_en   = 1'b1;
                    rd_addr = slot(r_head, r_i);
                    n_state = S_REV_B;
                end else begin
                    n_state = S_FRONT;
                end
            end
            S_REV_B: begin
                n_lo    = r_rdata;
                rd_en   = 1'b1;
                rd_addr = slot(r_head, hi_pos);
                n_state = S_REV_C;
            end
            S_REV_C: begin
                wr_en   = 1'b1;
                wr_addr = slot(r_head, r_i);
                n_state = S_REV_D;
            end
            S_REV_D: begin
                wr_en   = 1'b1;
                wr_addr = slot(r_head, hi_pos);
                wr_data = r_lo;
                n_i     = r_i + ONE_C;
                n_state = S_REV_A;
            end
            S_SORT_KEY: begin
                if (r_i < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = slot(r_head, r_i);
                    n_state = S_SORT_KEYW;
                end else begin
                    n_state = S_FRONT;
                end
            end
            S_SORT_KEYW: begin
                // r_lo holds the key while it walks down
                n_lo    = r_rdata;
                n_j     = r_i;
                rd_en   = 1'b1;
                rd_addr = slot(r_head, r_i - ONE_C);
                n_state = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                wr_en   = 1'b1;
                wr_addr = slot(r_head, r_j);
                if ($signed(r_rdata) > $signed(r_lo)) begin
                    n_j = r_j - ONE_C;
                    if (r_j == ONE_C) begin
                        n_state = S_SORT_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = slot(r_head, r_j - CW'(2));
                    end
                end else begin
                    wr_data = r_lo;
                    n_i     = r_i + ONE_C;
                    n_state = S_SORT_KEY;
                end
            end
            S_SORT_PUT: begin
                wr_en   = 1'b1;
                wr_addr = slot(r_head, r_j);
                wr_data = r_lo;
                n_i     = r_i + ONE_C;
                n_state = S_SORT_KEY;
            end
            S_FRONT: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_state = S_BACK;
            end
            S_BACK: begin
                n_front = (r_count != '0) ? r_rdata : WORD_NONE;
                rd_en   = 1'b1;
                rd_addr = slot(r_head, r_count - ONE_C);
                n_state = S_FIN;
            end
            S_FIN: begin
                // read data holds while the result waits for a free register
                if (!r_out_valid || i_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.status         = r_status;
                    n_out.removed_value  = (r_status != ST_OK) ? WORD_NONE : r_removed;
                    n_out.front_value    = r_front;
                    n_out.back_value     = (r_count != '0) ? r_rdata : WORD_NONE;
                    n_out.size_now       = 7'(r_count);
                    n_out.is_empty       = (r_count == '0);
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_i       <= n_i;
        r_j       <= n_j;
        r_req     <= n_req;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_lo      <= n_lo;
        r_front   <= n_front;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("element count above capacity");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("command taken while another is in flight");

    a_error_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status != ST_OK) |-> (o_data.removed_value == WORD_NONE))
        else $error("failed command reports a removed word");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.is_empty == (o_data.size_now == 7'd0)))
        else $error("empty flag disagrees with size");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same slot");

endmodule

@@ dv/double_ended_queue_top_tb.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// self-checking bench for the ring-store deque: a directed table of commands
// followed by weighted random traffic, each result checked against a
// behavioral deque kept in the bench, with bursty sender and stalling receiver
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import deq_pkg::*;

    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int RANDOM_ITEMS = 1000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    t_deq_in  cmd_data = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    t_deq_out res_data;

    double_ended_queue_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (cmd_valid),
        .o_ready (cmd_ready),
        .i_data  (cmd_data),
        .o_valid (res_valid),
        .i_ready (res_ready),
        .o_data  (res_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // behavioral deque, kept in logical order (index 0 is the front)
    logic [31:0] deq_words[$];
    t_deq_out    expected_results[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycles = 0;
    int          cmd_hits[16];
    bit          stim_done = 1'b0;

    function automatic t_deq_out deque_apply(t_deq_in c);
        t_deq_out    r;
        logic [31:0] key;
        int          j;
        r = '0;
        r.status = ST_OK;
        case (c.cmd) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (deq_words.size() >= CAPACITY) r.status = ST_FULL;
                else if (c.cmd == CMD_PUSH_FRONT) deq_words.insert(0, c.value);
                else deq_words.insert(deq_words.size(), c.value);
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (deq_words.size() == 0) r.status = ST_EMPTY;
                else if (c.cmd == CMD_POP_FRONT) begin
                    r.removed_value = deq_words[0];
                    deq_words.delete(0);
                end else begin
                    r.removed_value = deq_words[$];
                    deq_words.delete(deq_words.size() - 1);
                end
            end
            CMD_CLEAR: deq_words.delete();
            CMD_ERASE: begin
                if (c.index >= deq_words.size()) r.status = ST_RANGE;
                else begin
                    r.removed_value = deq_words[c.index];
                    deq_words.delete(c.index);
                end
            end
            CMD_RESIZE: begin
                if (c.count > CAPACITY) r.status = ST_FULL;
                else begin
                    while (deq_words.size() < c.count)
                        deq_words.insert(deq_words.size(), '0);
                    while (deq_words.size() > c.count)
                        deq_words.delete(deq_words.size() - 1);
                end
            end
            CMD_ASSIGN: begin
                if (c.count > CAPACITY) r.status = ST_FULL;
                else begin
                    deq_words.delete();
                    repeat (c.count) deq_words.insert(deq_words.size(), c.value);
                end
            end
            CMD_REVERSE: deq_words.reverse();
            CMD_SORT: begin
                for (int i = 1; i < deq_words.size(); i++) begin
                    key = deq_words[i];
                    j = i;
                    while (j > 0 && $signed(deq_words[j-1]) > $signed(key)) begin
                        deq_words[j] = deq_words[j-1];
                        j--;
                    end
                    deq_words[j] = key;
                end
            end
            default: ;
        endcase
        if (r.status != ST_OK) r.removed_value = WORD_NONE;
        r.size_now = 7'(deq_words.size());
        r.is_empty = (deq_words.size() == 0);
        r.front_value = r.is_empty ? WORD_NONE : deq_words[0];
        r.back_value = r.is_empty ? WORD_NONE : deq_words[$];
        return r;
    endfunction

    // drive one command and wait for its transfer; valid stays high afterwards
    task automatic send_cmd(t_deq_in c);
        t_deq_out e;
        cmd_valid <= 1'b1;
        cmd_data <= c;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        e = deque_apply(c);
        expected_results.insert(expected_results.size(), e);
        cmd_hits[c.cmd]++;
    endtask

    task automatic drain_results();
        while (expected_results.size() != 0 && cycles < LIMIT_CYCLES) @(posedge clk);
    endtask

    // receiver stall pattern: alternating stall-heavy and stall-free windows
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (!rst_n) res_ready <= 1'b0;
        else if (cycles[9]) res_ready <= 1'b1;
        else res_ready <= ($urandom_range(0, 99) < 60);
    end

    always @(posedge clk) begin
        t_deq_out want;
        if (rst_n && res_valid && res_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", res_data);
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (res_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp %p got %p", results_seen, want, res_data);
                end
            end
        end
    end

    typedef struct {
        t_deq_in  c;
        bit       has_exp;
        t_deq_out exp;
    } t_dir_row;

    t_dir_row dir[$];

    function automatic void add_row(t_deq_in c, bit has_exp, t_deq_out exp);
        t_dir_row row;
        row.c = c;
        row.has_exp = has_exp;
        row.exp = exp;
        dir.insert(dir.size(), row);
    endfunction

    function automatic t_deq_out res_of(logic [1:0] st, logic [31:0] rm, logic [31:0] f,
                                        logic [31:0] b, logic [6:0] n);
        t_deq_out r;
        r.status = st;
        r.removed_value = rm;
        r.front_value = f;
        r.back_value = b;
        r.size_now = n;
        r.is_empty = (n == 0);
        return r;
    endfunction

    function automatic t_deq_in mk(logic [3:0] c, logic [31:0] v, logic [5:0] i,
                                   logic [6:0] n);
        t_deq_in x;
        x.cmd = c;
        x.value = v;
        x.index = i;
        x.count = n;
        return x;
    endfunction

    function automatic t_deq_in rand_cmd();
        int          sel;
        logic [31:0] v;
        t_deq_in     x;
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            default: v = $urandom();
        endcase
        x = mk(CMD_PUSH_BACK, v, 6'($urandom_range(0, 63)), 7'($urandom_range(0, 12)));
        if (sel < 22) x.cmd = CMD_PUSH_FRONT;
        else if (sel < 44) x.cmd = CMD_PUSH_BACK;
        else if (sel < 56) x.cmd = CMD_POP_FRONT;
        else if (sel < 68) x.cmd = CMD_POP_BACK;
        else if (sel < 70) x.cmd = CMD_CLEAR;
        else if (sel < 78) begin
            x.cmd = CMD_ERASE;
            if (deq_words.size() > 0 && $urandom_range(0, 3) != 0)
                x.index = 6'($urandom_range(0, deq_words.size() - 1));
        end else if (sel < 83) x.cmd = CMD_RESIZE;
        else if (sel < 87) x.cmd = CMD_ASSIGN;
        else if (sel < 92) x.cmd = CMD_REVERSE;
        else if (sel < 97) x.cmd = CMD_SORT;
        else x.cmd = 4'($urandom_range(10, 15));
        // occasionally hit full sizes and the out-of-range count
        if ((x.cmd == CMD_RESIZE || x.cmd == CMD_ASSIGN) && $urandom_range(0, 9) == 0)
            x.count = 7'($urandom_range(63, 127));
        return x;
    endfunction

    initial begin
        t_deq_out got;
        int       burst;
        int       sent;
        for (int k = 0; k < 16; k++) cmd_hits[k] = 0;

        add_row(mk(CMD_POP_FRONT, 0, 0, 0), 1,
                res_of(ST_EMPTY, WORD_NONE, WORD_NONE, WORD_NONE, 0));
        add_row(mk(CMD_POP_BACK, 0, 0, 0), 1,
                res_of(ST_EMPTY, WORD_NONE, WORD_NONE, WORD_NONE, 0));
        add_row(mk(CMD_ERASE, 0, 0, 0), 1,
                res_of(ST_RANGE, WORD_NONE, WORD_NONE, WORD_NONE, 0));
        add_row(mk(CMD_PUSH_BACK, 32'h7FFF_FFFF, 0, 0), 1,
                res_of(ST_OK, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        add_row(mk(CMD_PUSH_FRONT, 32'h8000_0000, 0, 0), 1,
                res_of(ST_OK, 0, 32'h8000_0000, 32'h7FFF_FFFF, 2));
        add_row(mk(CMD_PUSH_BACK, 32'hFFFF_FFFF, 6'h3F, 7'h7F), 0, '0);
        add_row(mk(CMD_REVERSE, 0, 0, 0), 0, '0);
        add_row(mk(CMD_SORT, 0, 0, 0), 0, '0);
        add_row(mk(CMD_ERASE, 0, 1, 0), 0, '0);
        add_row(mk(CMD_ERASE, 0, 6'h3F, 0), 1,
                res_of(ST_RANGE, WORD_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 2));
        add_row(mk(CMD_RESIZE, 0, 0, 7'd65), 1,
                res_of(ST_FULL, WORD_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 2));
        add_row(mk(CMD_RESIZE, 0, 0, 7'd5), 1,
                res_of(ST_OK, 0, 32'h8000_0000, 0, 5));
        add_row(mk(CMD_RESIZE, 0, 0, 7'd1), 0, '0);
        add_row(mk(CMD_ASSIGN, 32'h1234_5678, 0, 7'd64), 1,
                res_of(ST_OK, 0, 32'h1234_5678, 32'h1234_5678, 64));
        add_row(mk(CMD_PUSH_FRONT, 1, 0, 0), 1,
                res_of(ST_FULL, WORD_NONE, 32'h1234_5678, 32'h1234_5678, 64));
        add_row(mk(CMD_PUSH_BACK, 1, 0, 0), 1,
                res_of(ST_FULL, WORD_NONE, 32'h1234_5678, 32'h1234_5678, 64));
        add_row(mk(CMD_ERASE, 0, 6'h3F, 0), 0, '0);
        add_row(mk(CMD_ASSIGN, 5, 0, 7'h7F), 0, '0);
        add_row(mk(CMD_CLEAR, 0, 0, 0), 1,
                res_of(ST_OK, 0, WORD_NONE, WORD_NONE, 0));
        add_row(mk(4'd10, 32'hFFFF_FFFF, 6'h3F, 7'h7F), 1,
                res_of(ST_OK, 0, WORD_NONE, WORD_NONE, 0));
        add_row(mk(4'd15, 0, 0, 0), 0, '0);
        add_row(mk(CMD_ASSIGN, 32'hFFFF_FFFE, 0, 7'd0), 1,
                res_of(ST_OK, 0, WORD_NONE, WORD_NONE, 0));
        add_row(mk(CMD_SORT, 0, 0, 0), 0, '0);
        add_row(mk(CMD_REVERSE, 0, 0, 0), 0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[k]) begin
            send_cmd(dir[k].c);
            if (dir[k].has_exp) begin
                got = expected_results[$];
                if (got !== dir[k].exp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("directed row %0d: table %p predicted %p", k, dir[k].exp, got);
                end
            end
        end
        cmd_valid <= 1'b0;
        // hold off until the directed results are all back
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS && cycles < LIMIT_CYCLES) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_cmd(rand_cmd());
                sent++;
            end
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done || cycles >= LIMIT_CYCLES);
        while (expected_results.size() != 0 && cycles < LIMIT_CYCLES) @(posedge clk);
        repeat (300) @(posedge clk);
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
        end else begin
            $display("covered %0d results over directed and random traffic", results_seen);
            $display("commands per code 0..9: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                     cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3], cmd_hits[4],
                     cmd_hits[5], cmd_hits[6], cmd_hits[7], cmd_hits[8], cmd_hits[9]);
            if (mismatches == 0 && expected_results.size() == 0) $display("ALL CHECKS PASSED");
            else begin
                $display("%0d mismatches, %0d results missing", mismatches,
                         expected_results.size());
                $display("CHECKS FAILED");
            end
        end
        $finish;
    end
endmodule
